// ===== sv/brbq_pkg.sv =====
// Shared types and codes for the byte ring buffer queue.
`timescale 1ns / 1ps

package brbq_pkg;

  // Command codes
  localparam logic [2:0] CMD_PUT     = 3'd0;
  localparam logic [2:0] CMD_GET     = 3'd1;
  localparam logic [2:0] CMD_PEEK    = 3'd2;
  localparam logic [2:0] CMD_REMOVE  = 3'd3;
  localparam logic [2:0] CMD_ADVANCE = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;

  // Result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_REJECT = 2'd3;

  localparam logic [12:0] RUN_COUNT_MAX = 13'h1FFF;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_BURST
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  data_in;
    logic        put_last;
    logic [12:0] length;
  } request_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic [12:0] count;
    logic [11:0] used_bytes;
    logic [11:0] free_bytes;
    logic [1:0]  status;
    logic        last;
  } result_t;

endpackage

// ===== sv/byte_ring_buffer_queue.sv =====
// Byte ring buffer queue: top level with the byte store and command sequencer.
`timescale 1ns / 1ps

// A circular byte queue over a DEPTH-byte synchronous store, holding at most
// DEPTH - RESERVE bytes. A command beat is taken when start is high and busy
// is low. Put, remove, advance write and clear leave busy low, so put bytes
// stream in at one beat per cycle while busy stays low. Get and peek keep
// busy high while the store read port fetches one byte a cycle; each result
// beat comes out in the cycle after its read. After reset the store is zeroed
// by a clearing pass over every address, during which busy is high. Results
// appear for exactly one cycle with strobe high; the receiver cannot stall
// them and must take every beat.
module byte_ring_buffer_queue
  import brbq_pkg::*;
#(
  parameter int DEPTH     = 4096,
  parameter int RESERVE   = 1,
  parameter int MAX_BURST = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     strobe,
  output result_t  result
);

  localparam int IW  = $clog2(DEPTH);
  localparam int SW  = (IW + 1 > 14) ? IW + 1 : 14;
  localparam int NW  = $clog2(MAX_BURST + 1);
  localparam int CAP = DEPTH - RESERVE;

  state_t state, state_next;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [IW-1:0] rd_addr;

  logic [IW-1:0] rd_index, wr_index, clr_addr, base;
  logic [NW-1:0] burst_n, burst_i;
  logic [12:0]   run_count, run_count_next;
  logic          run_dropped, run_dropped_next;

  logic          res_valid, res_byte, res_last;
  logic [12:0]   res_count;
  logic [1:0]    res_status;

  logic          accept, put_ok, burst_done;
  logic [SW-1:0] used_w, free_w, len_w, take_w;
  logic [IW:0]   rm_sum, adv_sum, inc_sum, addr_sum;
  logic [IW-1:0] rm_next, adv_next, inc_next;

  assign accept = start && !busy;
  assign len_w  = SW'(request.length);

  // Occupancy from the two indices
  always_comb begin
    if (wr_index >= rd_index) begin
      used_w = SW'(wr_index) - SW'(rd_index);
    end else begin
      used_w = SW'(wr_index) + SW'(DEPTH) - SW'(rd_index);
    end
    free_w = (used_w >= SW'(CAP)) ? '0 : SW'(CAP) - used_w;
  end

  // Index arithmetic, wrapping modulo DEPTH
  always_comb begin
    rm_sum   = {1'b0, rd_index} + (IW + 1)'(request.length);
    adv_sum  = {1'b0, wr_index} + (IW + 1)'(request.length);
    inc_sum  = {1'b0, wr_index} + (IW + 1)'(1);
    addr_sum = {1'b0, base} + (IW + 1)'(burst_i);
    rm_next  = (rm_sum >= (IW + 1)'(DEPTH)) ? IW'(rm_sum - (IW + 1)'(DEPTH)) : IW'(rm_sum);
    adv_next = (adv_sum >= (IW + 1)'(DEPTH)) ? IW'(adv_sum - (IW + 1)'(DEPTH))
                                             : IW'(adv_sum);
    inc_next = (inc_sum >= (IW + 1)'(DEPTH)) ? IW'(inc_sum - (IW + 1)'(DEPTH))
                                             : IW'(inc_sum);
    rd_addr  = (addr_sum >= (IW + 1)'(DEPTH)) ? IW'(addr_sum - (IW + 1)'(DEPTH))
                                              : IW'(addr_sum);
  end

  // Clamp the burst to MAX_BURST and to the bytes held
  always_comb begin
    take_w = len_w;
    if (take_w > SW'(MAX_BURST)) begin
      take_w = SW'(MAX_BURST);
    end
    if (take_w > used_w) begin
      take_w = used_w;
    end
  end

  // Put run bookkeeping
  assign put_ok = (free_w != '0);
  always_comb begin
    run_count_next   = run_count;
    run_dropped_next = run_dropped;
    if (put_ok) begin
      if (run_count != RUN_COUNT_MAX) begin
        run_count_next = run_count + 13'd1;
      end
    end else begin
      run_dropped_next = 1'b1;
    end
  end

  assign burst_done = (burst_i == burst_n - NW'(1));

  // Store write port: clearing pass or accepted put byte
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 8'd0;
    end else begin
      mem_we    = accept && (request.command == CMD_PUT) && put_ok;
      mem_waddr = wr_index;
      mem_wdata = request.data_in;
    end
  end

  // Store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == IW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && (request.command == CMD_GET || request.command == CMD_PEEK) &&
            used_w != '0 && take_w != '0) begin
          state_next = S_BURST;
        end
      end
      S_BURST: begin
        if (burst_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    unique case (state)
      S_IDLE:  busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  // Advance an index by a burst length, wrapping modulo DEPTH
  function automatic logic [IW-1:0] rd_addr_after(input logic [IW-1:0] idx,
                                                   input logic [SW-1:0] n);
    logic [IW:0] s;
    s = {1'b0, idx} + (IW + 1)'(n);
    return (s >= (IW + 1)'(DEPTH)) ? IW'(s - (IW + 1)'(DEPTH)) : IW'(s);
  endfunction

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      rd_index    <= '0;
      wr_index    <= '0;
      run_count   <= '0;
      run_dropped <= 1'b0;
      res_valid   <= 1'b0;
      burst_i     <= '0;
    end else begin
      state     <= state_next;
      res_valid <= 1'b0;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IW'(1);
      end
      if (state == S_BURST) begin
        res_valid <= 1'b1;
        burst_i   <= burst_i + NW'(1);
      end
      if (accept) begin
        case (request.command)
          CMD_PUT: begin
            if (put_ok) begin
              wr_index <= inc_next;
            end
            if (request.put_last) begin
              res_valid   <= 1'b1;
              run_count   <= '0;
              run_dropped <= 1'b0;
            end else begin
              run_count   <= run_count_next;
              run_dropped <= run_dropped_next;
            end
          end
          CMD_GET, CMD_PEEK: begin
            burst_i <= '0;
            if (used_w == '0 || take_w == '0) begin
              res_valid <= 1'b1;
            end else if (request.command == CMD_GET) begin
              rd_index <= rd_addr_after(rd_index, take_w);
            end
          end
          CMD_REMOVE: begin
            res_valid <= 1'b1;
            if (len_w <= used_w) begin
              rd_index <= rm_next;
            end
          end
          CMD_ADVANCE: begin
            res_valid <= 1'b1;
            if (len_w <= free_w) begin
              wr_index <= adv_next;
            end
          end
          CMD_CLEAR: begin
            res_valid <= 1'b1;
            rd_index  <= '0;
            wr_index  <= '0;
          end
          default: begin
            res_valid <= 1'b1;
          end
        endcase
      end
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    if (state == S_BURST) begin
      res_byte   <= 1'b1;
      res_count  <= 13'(burst_n);
      res_status <= STAT_OK;
      res_last   <= burst_done;
    end else if (accept) begin
      res_byte <= 1'b0;
      res_last <= 1'b1;
      case (request.command)
        CMD_PUT: begin
          res_count  <= run_count_next;
          res_status <= run_dropped_next ? STAT_FULL : STAT_OK;
        end
        CMD_GET, CMD_PEEK: begin
          res_count  <= '0;
          res_status <= (used_w == '0) ? STAT_EMPTY : STAT_OK;
          base       <= rd_index;
          burst_n    <= NW'(take_w);
        end
        CMD_REMOVE: begin
          res_count  <= (len_w <= used_w) ? request.length : '0;
          res_status <= (len_w <= used_w) ? STAT_OK : STAT_REJECT;
        end
        CMD_ADVANCE: begin
          res_count  <= (len_w <= free_w) ? request.length : '0;
          res_status <= (len_w <= free_w) ? STAT_OK : STAT_REJECT;
        end
        CMD_CLEAR: begin
          res_count  <= '0;
          res_status <= STAT_OK;
        end
        default: begin
          res_count  <= '0;
          res_status <= STAT_REJECT;
        end
      endcase
    end
  end

  // Drive the result beat; occupancy shows the indices after the command
  assign strobe = res_valid;
  always_comb begin
    result.data_out   = res_byte ? mem_q : 8'd0;
    result.count      = res_count;
    result.used_bytes = used_w[11:0];
    result.free_bytes = free_w[11:0];
    result.status     = res_status;
    result.last       = res_last;
  end

endmodule

// ===== sv/brbq_checker.sv =====
// Port-level checks for the byte ring buffer queue, bound to the top level.
`timescale 1ns / 1ps

module brbq_checker
  import brbq_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input request_t request,
  input logic     strobe,
  input result_t  result
);

  // A beat that is not the last of a burst is followed by the next beat
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("burst beat not followed by another beat");

  // Mid-burst beats only appear while the block holds off commands
  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("mid-burst beat while not busy");

  // An empty report shows an empty queue and no byte
  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    strobe && result.status == STAT_EMPTY |-> result.used_bytes == 12'd0 &&
    result.count == 13'd0 && result.data_out == 8'd0)
    else $error("empty status with bytes held");

  // No beat in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !strobe)
    else $error("result beat straight after reset");

endmodule

bind byte_ring_buffer_queue brbq_checker u_brbq_checker (.*);
